FILE: rtl/ifpq_pkg.sv
// ----------------------------------------------------------------------------
// ifpq_pkg
// Types and constants used by the field pacing queue.
// ----------------------------------------------------------------------------
package ifpq_pkg;

	localparam int ADDR_W  = 32;
	localparam int ENTRY_W = ADDR_W + 2;

	// One stored field: reset flag on top, then parity, then payload
	typedef struct packed {
		logic              count_reset;
		logic              parity;
		logic [ADDR_W-1:0] addr;
	} field_t;

	typedef enum logic [2:0] {
		ST_ACCEPT = 3'd0,
		ST_DROP   = 3'd1,
		ST_BROKEN = 3'd2,
		ST_NEW    = 3'd3,
		ST_DUP    = 3'd4,
		ST_SKIP   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WR1,
		S_WR2,
		S_EVAL,
		S_EVAL2,
		S_FIN
	} state_t;

	localparam logic signed [4:0] RATE_MAX = 5'sd10;
	localparam logic signed [4:0] RATE_MIN = -5'sd10;
	localparam logic signed [4:0] RATE_HI  = 5'sd3;
	localparam logic signed [4:0] RATE_LO  = -5'sd3;

	localparam logic [2:0] STARTUP_NEW = 3'd4;
	localparam logic [2:0] STARTUP_MAX = 3'd6;

endpackage

FILE: rtl/ifpq_ram.sv
// ----------------------------------------------------------------------------
// ifpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ifpq_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/interlaced_field_pacing_queue.sv
// ----------------------------------------------------------------------------
// interlaced_field_pacing_queue
// Field queue and display pacer for a deinterlacer: frame pushes fill a ring
// of field entries, display ticks choose new, duplicate or skip fields.
// ----------------------------------------------------------------------------
// Sequence: an accepted push writes two entries (S_WR1, S_WR2), a tick reads
//   the head (S_EVAL) and pops a second entry (S_EVAL2) when needed, a drop or
//   empty tick goes straight to S_FIN; S_FIN loads the result register.
// Handshake: one request at a time; S_FIN waits while a previous result stalls.
// Reset: pointers, started flag, current field, rate and startup counters
//   clear at once; field RAM contents are undefined and never read unwritten.
// ----------------------------------------------------------------------------
module interlaced_field_pacing_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [31:0]        frame_addr,
	input  logic               odd_first,
	input  logic               count_reset,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [31:0]        field_addr,
	output logic               field_parity,
	output logic               field_count_reset,
	output logic               format_set,
	output logic               format_value,
	output logic signed [4:0]  rate_level
);
	import ifpq_pkg::*;

	localparam int SW   = $clog2(QUEUE_DEPTH);
	localparam int PW   = $clog2(2 * QUEUE_DEPTH);
	localparam int SPAN = 2 * QUEUE_DEPTH;

	state_t state_q, state_nxt;

	logic [PW-1:0]      wp_q, rp_q;
	logic               started_q;
	field_t             cur_q;
	logic signed [4:0]  rate_q;
	logic [2:0]         startup_q;

	// latched request
	logic [ADDR_W-1:0]  addr_q;
	logic               par_q;
	logic               rst_q;
	logic               tick_q;

	// result under construction
	field_t             f_q;
	status_t            status_q;

	logic               out_valid_q;

	logic               ram_we;
	logic [SW-1:0]      ram_waddr, ram_raddr;
	field_t             ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	field_t             nxt_field;

	logic [PW-1:0]      fill, wp_next, rp_next;
	logic               q_full, q_empty;
	logic               out_free;

	status_t            fin_status;
	logic signed [4:0]  fin_rate;
	logic               fin_fset, fin_fval;
	field_t             fin_field;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(SPAN - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
		slot_of = s[SW-1:0];
	endfunction

	assign wp_next  = ptr_inc(wp_q);
	assign rp_next  = ptr_inc(rp_q);
	assign fill     = (wp_q >= rp_q) ? wp_q - rp_q : wp_q + PW'(SPAN) - rp_q;
	assign q_full   = ({1'b0, fill} + (PW+1)'(2)) > (PW+1)'(QUEUE_DEPTH);
	assign q_empty  = (fill == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign nxt_field = field_t'(ram_rdata);

	ifpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!mode) begin
						state_nxt = q_full ? S_FIN : S_WR1;
					end else begin
						state_nxt = q_empty ? S_FIN : S_EVAL;
					end
				end
			end
			S_WR1: state_nxt = S_WR2;
			S_WR2: state_nxt = S_FIN;
			S_EVAL: begin
				if (started_q && (cur_q.parity != nxt_field.parity) && cur_q.parity
						&& (fill >= PW'(3))) begin
					state_nxt = S_EVAL2;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_EVAL2: state_nxt = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// FSM outputs: handshake and RAM ports
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = slot_of(wp_q);
		ram_wdata = '{count_reset: rst_q, parity: par_q, addr: addr_q};
		ram_raddr = slot_of(rp_q);
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_WR1:  ram_we = 1'b1;
			S_WR2: begin
				ram_we           = 1'b1;
				ram_wdata.parity = ~par_q;
			end
			S_EVAL: ram_raddr = slot_of(rp_next);
			S_EVAL2, S_FIN: begin
			end
			default: in_stall = 1'b1;
		endcase
	end

	// tick finish: startup override, rate counter, format select
	always_comb begin
		fin_status = (startup_q < STARTUP_NEW) ? ST_NEW : status_q;
		fin_rate   = rate_q;
		if (fin_status == ST_SKIP && rate_q < RATE_MAX) begin
			fin_rate = rate_q + 5'sd1;
		end else if (fin_status == ST_DUP && rate_q > RATE_MIN) begin
			fin_rate = rate_q - 5'sd1;
		end
		fin_fset = (fin_rate <= RATE_LO) || (fin_rate >= RATE_HI);
		fin_fval = (fin_rate >= RATE_HI);
		fin_field = f_q;
		if (startup_q < STARTUP_NEW) begin
			fin_field.parity = startup_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			started_q   <= 1'b0;
			cur_q       <= '0;
			rate_q      <= '0;
			startup_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_WR1, S_WR2: wp_q <= wp_next;
				S_EVAL: begin
					rp_q      <= rp_next;
					started_q <= 1'b1;
				end
				// rp_q already points past the dropped entry
				S_EVAL2: rp_q <= rp_next;
				S_FIN: begin
					if (out_free) begin
						if (tick_q) begin
							rate_q <= fin_rate;
							cur_q  <= fin_field;
							if (startup_q < STARTUP_MAX) begin
								startup_q <= startup_q + 3'd1;
							end
						end
					end
				end
				S_IDLE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				addr_q <= frame_addr;
				par_q  <= odd_first;
				rst_q  <= count_reset;
				tick_q <= in_valid && mode && (started_q || !q_empty);
				if (in_valid && mode && q_empty && started_q) begin
					f_q <= cur_q;
				end else begin
					f_q <= '0;
				end
				if (in_valid) begin
					if (!mode) begin
						status_q <= q_full ? ST_DROP : ST_ACCEPT;
					end else if (q_empty && !started_q) begin
						status_q <= ST_BROKEN;
					end else if (q_empty) begin
						status_q <= ST_DUP;
					end
				end
			end
			S_EVAL: begin
				// rp_q has not advanced yet, so the first pop is the head entry
				f_q <= nxt_field;
				if (!started_q) begin
					status_q <= ST_NEW;
				end else if ((cur_q.parity != nxt_field.parity)
						&& !(cur_q.parity && (fill >= PW'(3)))) begin
					status_q <= ST_NEW;
				end else begin
					status_q <= ST_SKIP;
				end
			end
			S_EVAL2: f_q <= nxt_field;
			S_FIN: begin
				if (out_free) begin
					if (tick_q) begin
						status            <= fin_status;
						field_addr        <= fin_field.addr;
						field_parity      <= fin_field.parity;
						field_count_reset <= fin_field.count_reset;
						format_set        <= fin_fset;
						format_value      <= fin_fval;
						rate_level        <= fin_rate;
					end else begin
						status            <= status_q;
						field_addr        <= '0;
						field_parity      <= 1'b0;
						field_count_reset <= 1'b0;
						format_set        <= 1'b0;
						format_value      <= 1'b0;
						rate_level        <= rate_q;
					end
				end
			end
			S_WR1, S_WR2: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
